FILE: src/ltrm_pkg.sv
`default_nettype none
package ltrm_pkg;
	localparam int TABLE_DEPTH = 64;
	localparam int COUNT_BITS = 16;
	localparam int IDX_BITS = $clog2(TABLE_DEPTH);
	localparam int USED_BITS = $clog2(TABLE_DEPTH + 1);
	localparam int CORDIC_STEPS = 16;
	localparam logic [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [1:0] ST_UPDATED = 2'd0;
	localparam logic [1:0] ST_ADDED = 2'd1;
	localparam logic [1:0] ST_NO_POSE = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	function automatic logic [31:0] atan_lut(input logic [3:0] i);
		logic [31:0] r;
		begin
			case (i)
				4'd0: r = 32'h20000000;
				4'd1: r = 32'h12E4051D;
				4'd2: r = 32'h09FB385B;
				4'd3: r = 32'h051111D4;
				4'd4: r = 32'h028B0D43;
				4'd5: r = 32'h0145D7E1;
				4'd6: r = 32'h00A2F61E;
				4'd7: r = 32'h00517C55;
				4'd8: r = 32'h0028BE53;
				4'd9: r = 32'h00145F2E;
				4'd10: r = 32'h000A2F98;
				4'd11: r = 32'h000517CC;
				4'd12: r = 32'h00028BE6;
				4'd13: r = 32'h000145F3;
				4'd14: r = 32'h0000A2F9;
				default: r = 32'h0000517C;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

FILE: src/ltrm_divider.sv
`default_nettype none
// Signed restoring divider, truncating toward zero: 33-bit dividend by a
// positive divisor of COUNT_BITS+1 bits, one quotient bit per cycle.
module ltrm_divider import ltrm_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	input  wire signed [32:0]      dividend,
	input  wire [COUNT_BITS:0]     divisor,
	output logic                   done,
	output logic signed [32:0]     quotient
);
	logic [32:0] mag_q;
	logic [32:0] quo_q;
	logic [COUNT_BITS+1:0] rem_q;
	logic [COUNT_BITS:0] dvs_q;
	logic neg_q;
	logic busy_q;
	logic [5:0] cnt_q;
	logic [COUNT_BITS+1:0] trial;
	logic [COUNT_BITS+1:0] shifted;

	assign shifted = {rem_q[COUNT_BITS:0], mag_q[32]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd32) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[32] ? 33'(-dividend) : 33'(dividend);
			neg_q <= dividend[32];
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[31:0], 1'b0};
			if (!trial[COUNT_BITS+1]) begin
				rem_q <= trial;
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule
`default_nettype wire

FILE: src/landmark_table_running_mean_top.sv
`default_nettype none
// Landmark table with running-mean positions.
// Input stream s_axis: one detection per request. Output stream m_axis:
// exactly one result per detection.
// Sequencing: CORDIC sin/cos (16 iterations on one shift-add unit), two
// range multiplies, a table search of one slot per cycle, and on a match two
// serial 33-step divides sharing one divider.
// With pose_valid low the result is valid in the cycle after the request.
// Otherwise it follows the table scan: a new entry, a full table, or a match
// that runs both divides. s_axis_tready is high only while idle.
// The result sits in an output register; the block takes the next request
// only after the result is taken, so a stalled receiver stalls the input.
// Reset clears the entry count; table contents need no clearing since only
// slots below the count are read.
module landmark_table_running_mean_top import ltrm_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// pose_valid[0], robot_x[32:1], robot_y[64:33], robot_yaw[80:65],
	// range[104:81], bearing[120:105], color_code[128:121], tag_number[144:129]
	input  wire [151:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// status[1:0], entry_index[7:2], landmark_x[39:8], landmark_y[71:40],
	// sighting_count[87:72]
	output logic [87:0]  m_axis_tdata
);
	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_ROT  = 10'b0000000010,
		S_MULX = 10'b0000000100,
		S_MULY = 10'b0000001000,
		S_SCAN = 10'b0000010000,
		S_RD   = 10'b0000100000,
		S_DIVX = 10'b0001000000,
		S_DIVY = 10'b0010000000,
		S_WR   = 10'b0100000000,
		S_OUT  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [USED_BITS-1:0] used_q;
	logic [USED_BITS-1:0] scan_q;
	logic [3:0] it_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [32:0] cz_q;
	logic flip_q;
	logic signed [31:0] rx_q, ry_q, px_q, py_q;
	logic [23:0] rng_q;
	logic [7:0] col_q;
	logic [15:0] tag_q;
	logic [IDX_BITS-1:0] slot_q;
	logic signed [31:0] ox_q, oy_q;
	logic [COUNT_BITS-1:0] oc_q;
	logic [1:0] st_q;
	logic [87:0] out_q;

	logic signed [31:0] mem_x [TABLE_DEPTH];
	logic signed [31:0] mem_y [TABLE_DEPTH];
	logic [23:0] mem_sig [TABLE_DEPTH];
	logic [COUNT_BITS-1:0] mem_cnt [TABLE_DEPTH];
	logic [23:0] sig_rd_q;
	logic sig_ok_q;
	logic [IDX_BITS-1:0] sig_idx_q;

	logic [15:0] ang;
	logic signed [33:0] xs, ys;
	logic signed [33:0] cos_v, sin_v;
	logic signed [33:0] trig_sel;
	logic signed [58:0] prod;
	logic signed [28:0] offs;
	logic signed [33:0] sum;
	logic signed [31:0] sat;
	logic div_start, div_done;
	logic signed [32:0] div_num, div_quo;
	logic [COUNT_BITS:0] div_den;
	logic signed [31:0] mean;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata = out_q;
	assign ang = s_axis_tdata[80:65] + s_axis_tdata[120:105];

	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;
	assign cos_v = flip_q ? -cx_q : cx_q;
	assign sin_v = flip_q ? -cy_q : cy_q;
	assign trig_sel = (state_q == S_MULX) ? cos_v : sin_v;
	// single shared multiplier; offset is floor(range*trig / 2^30)
	assign prod = $signed({1'b0, rng_q}) * trig_sel;
	assign offs = 29'(prod >>> 30);
	assign sum = ((state_q == S_MULX) ? 34'(rx_q) : 34'(ry_q)) + 34'(offs);
	assign sat = (sum > 34'sd2147483647) ? 32'sh7FFFFFFF :
		(sum < -34'sd2147483648) ? 32'sh80000000 : 32'(sum);

	assign div_num = (state_q == S_DIVY) ? 33'(py_q) - 33'(oy_q) : 33'(px_q) - 33'(ox_q);
	assign div_den = {1'b0, oc_q} + 1'b1;
	assign mean = 32'(((state_q == S_DIVY) ? 33'(oy_q) : 33'(ox_q)) + div_quo);

	ltrm_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_num), .divisor(div_den),
		.done(div_done), .quotient(div_quo)
	);

	always_ff @(posedge clk) begin
		sig_rd_q <= mem_sig[scan_q[IDX_BITS-1:0]];
		sig_idx_q <= scan_q[IDX_BITS-1:0];
		if (state_q == S_RD) begin
			ox_q <= mem_x[slot_q];
			oy_q <= mem_y[slot_q];
			oc_q <= mem_cnt[slot_q];
		end else if (state_q == S_SCAN) begin
			// count of a new entry; a match reloads it from the table
			oc_q <= COUNT_BITS'(1);
		end else if (state_q == S_DIVY && div_done && oc_q != COUNT_MAX) begin
			oc_q <= oc_q + 1'b1;
		end
		if (state_q == S_WR) begin
			mem_x[slot_q] <= px_q;
			mem_y[slot_q] <= py_q;
			mem_cnt[slot_q] <= oc_q;
			mem_sig[slot_q] <= {tag_q, col_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			div_start <= 1'b0;
			sig_ok_q <= 1'b0;
		end else begin
			div_start <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_axis_tvalid) begin
					if (!s_axis_tdata[0]) begin
						out_q <= {86'd0, ST_NO_POSE};
						state_q <= S_OUT;
					end else begin
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					if (it_q == 4'(CORDIC_STEPS - 1)) state_q <= S_MULX;
				end
				S_MULX: begin
					px_q <= sat;
					state_q <= S_MULY;
				end
				S_MULY: begin
					py_q <= sat;
					sig_ok_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// the table read is registered: compare the slot fetched last cycle
					sig_ok_q <= (scan_q < used_q);
					if (sig_ok_q && sig_rd_q == {tag_q, col_q}) begin
						slot_q <= sig_idx_q;
						state_q <= S_RD;
					end else if (!sig_ok_q && scan_q == used_q) begin
						if (used_q == USED_BITS'(TABLE_DEPTH)) begin
							out_q <= {86'd0, ST_FULL};
							state_q <= S_OUT;
						end else begin
							slot_q <= used_q[IDX_BITS-1:0];
							used_q <= used_q + 1'b1;
							st_q <= ST_ADDED;
							state_q <= S_WR;
						end
					end
				end
				S_RD: begin
					div_start <= 1'b1;
					st_q <= ST_UPDATED;
					state_q <= S_DIVX;
				end
				S_DIVX: if (div_done) begin
					px_q <= mean;
					div_start <= 1'b1;
					state_q <= S_DIVY;
				end
				S_DIVY: if (div_done) begin
					py_q <= mean;
					state_q <= S_WR;
				end
				S_WR: begin
					out_q <= {16'(oc_q), py_q, px_q, 6'(slot_q), st_q};
					state_q <= S_OUT;
				end
				S_OUT: if (m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			rx_q <= s_axis_tdata[32:1];
			ry_q <= s_axis_tdata[64:33];
			rng_q <= s_axis_tdata[104:81];
			col_q <= s_axis_tdata[128:121];
			tag_q <= s_axis_tdata[144:129];
			flip_q <= (ang >= 16'h4000) && (ang < 16'hC000);
			cz_q <= 33'($signed({ang - (((ang >= 16'h4000) && (ang < 16'hC000)) ?
				16'h8000 : 16'h0000), 16'h0000}));
			cx_q <= CORDIC_GAIN;
			cy_q <= '0;
			it_q <= '0;
		end else if (state_q == S_ROT) begin
			it_q <= it_q + 1'b1;
			if (cz_q >= 0) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - $signed({1'b0, atan_lut(it_q)});
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + $signed({1'b0, atan_lut(it_q)});
			end
		end
		if (state_q == S_MULY) scan_q <= '0;
		else if (state_q == S_SCAN && scan_q < used_q) scan_q <= scan_q + 1'b1;
	end

`ifndef NO_ASSERTIONS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_BITS'(TABLE_DEPTH)) else $error("entry count overflow");
	a_ready_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_add_once: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != $past(used_q) |-> used_q == $past(used_q) + 1'b1)
		else $error("entry count jumped");
`endif
endmodule
`default_nettype wire
